@@ design/pqc_pkg.sv @@
package pqc_pkg;

  // Fixed field widths
  localparam int ACTION_BITS     = 2;
  localparam int SEG_INDEX_BITS  = 3;
  localparam int BREAK_BITS      = 8;
  localparam int PIXEL_PORT_BITS = 8;
  localparam int COEFF_BITS      = 32;
  localparam int VALUE_BITS      = 32;
  localparam int SEGCNT_BITS     = 4;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int CFG_DATA_BITS   = 32;

  // Parameter defaults
  localparam int DEF_MAX_SEGMENTS = 8;
  localparam int DEF_PIXEL_BITS   = 8;

  // Queue between front and back
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  // Datapath widths of the polynomial evaluation
  localparam int SQ_BITS    = 2 * PIXEL_PORT_BITS;
  localparam int LINX_BITS  = COEFF_BITS + PIXEL_PORT_BITS + 1;
  localparam int QX_BITS    = COEFF_BITS + SQ_BITS + 1;
  localparam int FRAC_DROP  = 12;
  localparam int LIN_SHIFT  = 4;
  localparam int SUM_BITS   = QX_BITS + 3;
  localparam int Q_BITS     = SUM_BITS - FRAC_DROP;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_CONVERT    = 2'd0,
    ACT_WRITE_SEG  = 2'd1,
    ACT_MARK_BAD   = 2'd2,
    ACT_CLEAR_MARK = 2'd3
  } action_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SEGMENT_COUNT    = 1'd0,
    REG_BAD_OUTPUT_VALUE = 1'd1
  } cfg_reg_t;

  // One classified convert item, segment already resolved
  typedef struct packed {
    logic                         bad;
    logic [PIXEL_PORT_BITS-1:0]   x;
    logic signed [COEFF_BITS-1:0] offset;
    logic signed [COEFF_BITS-1:0] linear;
    logic signed [COEFF_BITS-1:0] quad;
  } conv_t;

endpackage

@@ design/pqc_queue.sv @@
module pqc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pqc_pkg::conv_t din,
  output logic          full,
  input  logic          pop,
  output pqc_pkg::conv_t dout,
  output logic          empty
);
  import pqc_pkg::*;

  conv_t                     mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;

  assign full  = (count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("pop from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

@@ design/pqc_front.sv @@
module pqc_front #(
  parameter int MAX_SEGMENTS = pqc_pkg::DEF_MAX_SEGMENTS,
  parameter int PIXEL_BITS   = pqc_pkg::DEF_PIXEL_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic [pqc_pkg::ACTION_BITS-1:0]       action,
  input  logic [pqc_pkg::SEG_INDEX_BITS-1:0]    seg_index,
  input  logic [pqc_pkg::BREAK_BITS-1:0]        breakpoint,
  input  logic signed [pqc_pkg::COEFF_BITS-1:0] offset_coeff,
  input  logic signed [pqc_pkg::COEFF_BITS-1:0] linear_coeff,
  input  logic signed [pqc_pkg::COEFF_BITS-1:0] quad_coeff,
  input  logic [pqc_pkg::PIXEL_PORT_BITS-1:0]   pixel,
  input  logic [pqc_pkg::SEGCNT_BITS-1:0]       segment_count,
  output logic                                  q_push,
  output pqc_pkg::conv_t                        q_data,
  input  logic                                  q_full
);
  import pqc_pkg::*;

  localparam int XW = (PIXEL_BITS < PIXEL_PORT_BITS) ? PIXEL_BITS : PIXEL_PORT_BITS;
  localparam int MARK_DEPTH = 1 << XW;
  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int NW = $clog2(MAX_SEGMENTS + 1);

  // Segment table: breakpoints compared in parallel, coefficients read at one index
  logic [BREAK_BITS-1:0]        seg_breaks  [MAX_SEGMENTS];
  logic signed [COEFF_BITS-1:0] seg_offsets [MAX_SEGMENTS];
  logic signed [COEFF_BITS-1:0] seg_linears [MAX_SEGMENTS];
  logic signed [COEFF_BITS-1:0] seg_quads   [MAX_SEGMENTS];
  logic [MARK_DEPTH-1:0]        bad_marks;

  // Classify stage
  logic                         a_valid;
  action_t                      a_action;
  logic [SEG_INDEX_BITS-1:0]    a_seg_index;
  logic [BREAK_BITS-1:0]        a_break;
  logic signed [COEFF_BITS-1:0] a_off;
  logic signed [COEFF_BITS-1:0] a_lin;
  logic signed [COEFF_BITS-1:0] a_quad;
  logic [XW-1:0]                a_px;

  logic          accept;
  logic          a_stall;
  logic          a_go;
  logic          slot_ok;
  logic [IW-1:0] wr_slot;
  logic [NW-1:0] n_use;
  logic [IW-1:0] seg_sel;

  assign a_stall = (a_action == ACT_CONVERT) && q_full;
  assign full    = a_valid && a_stall;
  assign accept  = push && !full;
  assign a_go    = a_valid && !a_stall;
  assign slot_ok = (32'(a_seg_index) < MAX_SEGMENTS);
  assign wr_slot = IW'(a_seg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_go) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_action    <= action_t'(action);
      a_seg_index <= seg_index;
      a_break     <= breakpoint;
      a_off       <= offset_coeff;
      a_lin       <= linear_coeff;
      a_quad      <= quad_coeff;
      a_px        <= pixel[XW-1:0];
    end
  end

  // Commit table writes in item order
  always_ff @(posedge clk) begin
    if (a_go && (a_action == ACT_WRITE_SEG) && slot_ok) begin
      seg_breaks[wr_slot]  <= a_break;
      seg_offsets[wr_slot] <= a_off;
      seg_linears[wr_slot] <= a_lin;
      seg_quads[wr_slot]   <= a_quad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bad_marks <= '0;
    end else if (a_go && (a_action == ACT_MARK_BAD)) begin
      bad_marks[a_px] <= 1'b1;
    end else if (a_go && (a_action == ACT_CLEAR_MARK)) begin
      bad_marks[a_px] <= 1'b0;
    end
  end

  // Clamp segment count to 1..MAX_SEGMENTS
  always_comb begin
    if (segment_count == '0) begin
      n_use = NW'(1);
    end else if (32'(segment_count) > MAX_SEGMENTS) begin
      n_use = NW'(MAX_SEGMENTS);
    end else begin
      n_use = NW'(segment_count);
    end
  end

  // Leading run of exceeded breakpoints, clamped to the last segment in use
  always_comb begin
    seg_sel = IW'(n_use - 1'b1);
    for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
      if ((NW'(i + 1) < n_use) && !(PIXEL_PORT_BITS'(a_px) > seg_breaks[i])) begin
        seg_sel = IW'(i);
      end
    end
  end

  assign q_push        = a_valid && (a_action == ACT_CONVERT) && !q_full;
  assign q_data.bad    = bad_marks[a_px];
  assign q_data.x      = PIXEL_PORT_BITS'(a_px);
  assign q_data.offset = seg_offsets[seg_sel];
  assign q_data.linear = seg_linears[seg_sel];
  assign q_data.quad   = seg_quads[seg_sel];

endmodule

@@ design/pqc_back.sv @@
module pqc_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pqc_pkg::conv_t                        q_data,
  input  logic                                  q_empty,
  output logic                                  q_pop,
  input  logic signed [pqc_pkg::VALUE_BITS-1:0] bad_output_value,
  input  logic                                  pop,
  output logic                                  empty,
  output logic signed [pqc_pkg::VALUE_BITS-1:0] value,
  output logic                                  is_bad,
  output logic                                  saturated
);
  import pqc_pkg::*;

  logic en;

  // Stage 1: linear product and pixel square
  logic                         b1_valid;
  logic                         b1_bad;
  logic signed [COEFF_BITS-1:0] b1_off;
  logic signed [COEFF_BITS-1:0] b1_quad;
  logic signed [LINX_BITS-1:0]  b1_linx;
  logic [SQ_BITS-1:0]           b1_sq;

  // Stage 2: quadratic product
  logic                         b2_valid;
  logic                         b2_bad;
  logic signed [COEFF_BITS-1:0] b2_off;
  logic signed [LINX_BITS-1:0]  b2_linx;
  logic signed [QX_BITS-1:0]    b2_qx;

  logic                         out_valid;
  logic signed [SUM_BITS-1:0]   sum;
  logic signed [Q_BITS-1:0]     q16;
  logic                         ovf;
  logic signed [VALUE_BITS-1:0] clipped;

  assign en    = !out_valid || pop;
  assign q_pop = en && !q_empty;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b1_valid  <= q_pop;
      b2_valid  <= b1_valid;
      out_valid <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_bad  <= q_data.bad;
      b1_off  <= q_data.offset;
      b1_quad <= q_data.quad;
      b1_linx <= LINX_BITS'(q_data.linear) * LINX_BITS'($signed({1'b0, q_data.x}));
      b1_sq   <= SQ_BITS'(q_data.x) * SQ_BITS'(q_data.x);
      b2_bad  <= b1_bad;
      b2_off  <= b1_off;
      b2_linx <= b1_linx;
      b2_qx   <= QX_BITS'(b1_quad) * QX_BITS'($signed({1'b0, b1_sq}));
    end
  end

  // Exact sum in Q.28, floor to Q23.16, clip to 32 bits
  always_comb begin
    sum = (SUM_BITS'(b2_off) <<< FRAC_DROP)
        + (SUM_BITS'(b2_linx) <<< LIN_SHIFT)
        + SUM_BITS'(b2_qx);
    q16 = sum[SUM_BITS-1:FRAC_DROP];
    ovf = !((&q16[Q_BITS-1:VALUE_BITS-1]) || !(|q16[Q_BITS-1:VALUE_BITS-1]));
    if (!ovf) begin
      clipped = q16[VALUE_BITS-1:0];
    end else if (q16[Q_BITS-1]) begin
      clipped = {1'b1, {(VALUE_BITS-1){1'b0}}};
    end else begin
      clipped = {1'b0, {(VALUE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (b2_bad) begin
        value     <= bad_output_value;
        is_bad    <= 1'b1;
        saturated <= 1'b0;
      end else begin
        value     <= clipped;
        is_bad    <= 1'b0;
        saturated <= ovf;
      end
    end
  end

endmodule

@@ design/piecewise_quadratic_calibrator.sv @@
// Path: a convert item is registered in the classify stage, written to the
//   queue, then moves through stage 1, stage 2 and the result register.
// Throughput: one item per cycle when nothing downstream stalls; the two multiplier
//   stages and the four-entry queue between classify and evaluate pipeline fully.
// Reset (rst, synchronous): clears all bad marks, sets segment_count to 1 and
//   bad_output_value to 0; segment slots hold garbage until written.
module piecewise_quadratic_calibrator #(
  parameter int MAX_SEGMENTS = pqc_pkg::DEF_MAX_SEGMENTS,
  parameter int PIXEL_BITS   = pqc_pkg::DEF_PIXEL_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic [pqc_pkg::ACTION_BITS-1:0]        action,
  input  logic [pqc_pkg::SEG_INDEX_BITS-1:0]     seg_index,
  input  logic [pqc_pkg::BREAK_BITS-1:0]         breakpoint,
  input  logic signed [pqc_pkg::COEFF_BITS-1:0]  offset_coeff,
  input  logic signed [pqc_pkg::COEFF_BITS-1:0]  linear_coeff,
  input  logic signed [pqc_pkg::COEFF_BITS-1:0]  quad_coeff,
  input  logic [pqc_pkg::PIXEL_PORT_BITS-1:0]    pixel,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [pqc_pkg::VALUE_BITS-1:0]  value,
  output logic                                   is_bad,
  output logic                                   saturated,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pqc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [pqc_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
  import pqc_pkg::*;

  // Configuration registers
  logic [SEGCNT_BITS-1:0]       segment_count;
  logic signed [VALUE_BITS-1:0] bad_output_value;

  // Front to queue, queue to back
  logic  fq_push;
  conv_t fq_data;
  logic  fq_full;
  logic  qb_pop;
  conv_t qb_data;
  logic  qb_empty;

  // Config writes take effect at the next clock edge; the channel never back-pressures.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count    <= SEGCNT_BITS'(1);
      bad_output_value <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SEGMENT_COUNT:    segment_count    <= cfg_data[SEGCNT_BITS-1:0];
        REG_BAD_OUTPUT_VALUE: bad_output_value <= cfg_data[VALUE_BITS-1:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // Front: register each beat, commit table and mark updates in order,
  // resolve the segment and fetch its coefficients for convert beats.
  pqc_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .PIXEL_BITS   (PIXEL_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .action        (action),
    .seg_index     (seg_index),
    .breakpoint    (breakpoint),
    .offset_coeff  (offset_coeff),
    .linear_coeff  (linear_coeff),
    .quad_coeff    (quad_coeff),
    .pixel         (pixel),
    .segment_count (segment_count),
    .q_push        (fq_push),
    .q_data        (fq_data),
    .q_full        (fq_full)
  );

  // Decouple classification from evaluation so either side can stall alone.
  pqc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .din   (fq_data),
    .full  (fq_full),
    .pop   (qb_pop),
    .dout  (qb_data),
    .empty (qb_empty)
  );

  // Back: two multiply stages, then sum, floor, clip into the result register.
  pqc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_data           (qb_data),
    .q_empty          (qb_empty),
    .q_pop            (qb_pop),
    .bad_output_value (bad_output_value),
    .pop              (pop),
    .empty            (empty),
    .value            (value),
    .is_bad           (is_bad),
    .saturated        (saturated)
  );

endmodule
